// ===== design/hps_pkg.sv =====
// ----------------------------------------------------------------------------
// hps_pkg
// Types, constants and the microcode table of the Heston path stepper.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int DRAW_BITS  = 12;
  localparam int QUART_BITS = 2 * DRAW_BITS + 2;
  localparam int PC_W       = 6;
  localparam logic [PC_W-1:0] PROG_LAST = 6'd39;
  localparam logic signed [31:0] DRAW_ONE_SQ = 32'sd16777216;  // 1.0 squared in Q4.12 pairs
  localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] I32_MIN = -64'sd2147483648;

  localparam logic [2:0] REG_KAPPA = 3'd0;
  localparam logic [2:0] REG_THETA = 3'd1;
  localparam logic [2:0] REG_SIGMA = 3'd2;
  localparam logic [2:0] REG_RATE  = 3'd3;
  localparam logic [2:0] REG_DT    = 3'd4;
  localparam logic [2:0] REG_V0    = 3'd5;
  localparam logic [2:0] REG_S0    = 3'd6;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_MUL   = 5'b00100,
    S_SQRT  = 5'b01000,
    S_PUSH  = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    OP_MUL, OP_SQRT, OP_LD, OP_ADD, OP_SUB, OP_SAT
  } op_t;

  typedef enum logic [3:0] {
    SRC_KAPPA, SRC_THETA, SRC_SIGMA, SRC_RATE, SRC_DT, SRC_V, SRC_P,
    SRC_ZV, SRC_ZS, SRC_ZP, SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_ONE, SRC_ZSQ
  } src_t;

  typedef enum logic [1:0] {
    SH_NONE, SH_FRAC, SH_DRAW, SH_QUART
  } shift_t;

  typedef enum logic [2:0] {
    DST_T0, DST_T1, DST_T2, DST_T3, DST_V, DST_P, DST_NONE
  } dst_t;

  typedef struct packed {
    op_t    op;
    src_t   a;
    src_t   b;
    shift_t sh;
    dst_t   dst;
  } uop_t;

  function automatic uop_t mk(input op_t op, input src_t a, input src_t b,
                              input shift_t sh, input dst_t dst);
    uop_t u;
    u.op = op; u.a = a; u.b = b; u.sh = sh; u.dst = dst;
    return u;
  endfunction

  // variance step, then price step
  function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_LD,   SRC_THETA, SRC_ONE,   SH_NONE,  DST_NONE);
      6'd1:  u = mk(OP_SUB,  SRC_V,     SRC_ONE,   SH_NONE,  DST_NONE);
      6'd2:  u = mk(OP_SAT,  SRC_ONE,   SRC_ONE,   SH_NONE,  DST_T0);
      6'd3:  u = mk(OP_MUL,  SRC_KAPPA, SRC_T0,    SH_FRAC,  DST_T0);
      6'd4:  u = mk(OP_MUL,  SRC_T0,    SRC_DT,    SH_FRAC,  DST_T1);
      6'd5:  u = mk(OP_MUL,  SRC_V,     SRC_DT,    SH_FRAC,  DST_T0);
      6'd6:  u = mk(OP_SQRT, SRC_T0,    SRC_ONE,   SH_NONE,  DST_T0);
      6'd7:  u = mk(OP_MUL,  SRC_SIGMA, SRC_T0,    SH_FRAC,  DST_T0);
      6'd8:  u = mk(OP_MUL,  SRC_T0,    SRC_ZV,    SH_DRAW,  DST_T2);
      6'd9:  u = mk(OP_MUL,  SRC_SIGMA, SRC_SIGMA, SH_FRAC,  DST_T0);
      6'd10: u = mk(OP_MUL,  SRC_T0,    SRC_DT,    SH_FRAC,  DST_T0);
      6'd11: u = mk(OP_MUL,  SRC_ZV,    SRC_ZV,    SH_NONE,  DST_T3);
      6'd12: u = mk(OP_LD,   SRC_T3,    SRC_ONE,   SH_NONE,  DST_NONE);
      6'd13: u = mk(OP_SUB,  SRC_ZSQ,   SRC_ONE,   SH_NONE,  DST_NONE);
      6'd14: u = mk(OP_SAT,  SRC_ONE,   SRC_ONE,   SH_NONE,  DST_T3);
      6'd15: u = mk(OP_MUL,  SRC_T0,    SRC_T3,    SH_QUART, DST_T0);
      6'd16: u = mk(OP_LD,   SRC_V,     SRC_ONE,   SH_NONE,  DST_NONE);
      6'd17: u = mk(OP_ADD,  SRC_T1,    SRC_ONE,   SH_NONE,  DST_NONE);
      6'd18: u = mk(OP_ADD,  SRC_T2,    SRC_ONE,   SH_NONE,  DST_NONE);
      6'd19: u = mk(OP_ADD,  SRC_T0,    SRC_ONE,   SH_NONE,  DST_NONE);
      6'd20: u = mk(OP_SAT,  SRC_ONE,   SRC_ONE,   SH_NONE,  DST_V);
      6'd21: u = mk(OP_MUL,  SRC_V,     SRC_DT,    SH_FRAC,  DST_T0);
      6'd22: u = mk(OP_SQRT, SRC_T0,    SRC_ONE,   SH_NONE,  DST_T0);
      6'd23: u = mk(OP_MUL,  SRC_T0,    SRC_ZS,    SH_DRAW,  DST_T1);
      6'd24: u = mk(OP_MUL,  SRC_RATE,  SRC_DT,    SH_FRAC,  DST_T0);
      6'd25: u = mk(OP_LD,   SRC_ONE,   SRC_ONE,   SH_NONE,  DST_NONE);
      6'd26: u = mk(OP_ADD,  SRC_T0,    SRC_ONE,   SH_NONE,  DST_NONE);
      6'd27: u = mk(OP_ADD,  SRC_T1,    SRC_ONE,   SH_NONE,  DST_NONE);
      6'd28: u = mk(OP_SAT,  SRC_ONE,   SRC_ONE,   SH_NONE,  DST_T0);
      6'd29: u = mk(OP_MUL,  SRC_P,     SRC_T0,    SH_FRAC,  DST_T1);
      6'd30: u = mk(OP_MUL,  SRC_P,     SRC_P,     SH_FRAC,  DST_T0);
      6'd31: u = mk(OP_MUL,  SRC_T0,    SRC_DT,    SH_FRAC,  DST_T0);
      6'd32: u = mk(OP_MUL,  SRC_ZP,    SRC_ZP,    SH_NONE,  DST_T2);
      6'd33: u = mk(OP_LD,   SRC_T2,    SRC_ONE,   SH_NONE,  DST_NONE);
      6'd34: u = mk(OP_SUB,  SRC_ZSQ,   SRC_ONE,   SH_NONE,  DST_NONE);
      6'd35: u = mk(OP_SAT,  SRC_ONE,   SRC_ONE,   SH_NONE,  DST_T2);
      6'd36: u = mk(OP_MUL,  SRC_T0,    SRC_T2,    SH_QUART, DST_T0);
      6'd37: u = mk(OP_LD,   SRC_T1,    SRC_ONE,   SH_NONE,  DST_NONE);
      6'd38: u = mk(OP_ADD,  SRC_T0,    SRC_ONE,   SH_NONE,  DST_NONE);
      6'd39: u = mk(OP_SAT,  SRC_ONE,   SRC_ONE,   SH_NONE,  DST_P);
      default: u = mk(OP_LD, SRC_ONE,   SRC_ONE,   SH_NONE,  DST_NONE);
    endcase
    return u;
  endfunction

  // {overflow, clipped value}
  function automatic logic [32:0] sat32(input logic signed [63:0] x);
    logic [32:0] r;
    if (x > I32_MAX) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (x < I32_MIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

endpackage

// ===== design/heston_path_step.sv =====
// ----------------------------------------------------------------------------
// heston_path_step
// Heston path stepper: Milstein variance step and price update per beat,
// sequenced by microcode over a bit-serial multiplier and a 2-bit-per-cycle
// square root.
//
//   channel | dir | handshake            | payload
//   in      | in  | in_valid / in_ready  | path_start, normal_var, normal_price
//   out     | out | out_valid / out_ready| price, variance, saturated
//   cfg     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Path-start beat: goes straight to the push state, then the output register.
// Step beat: 17 multiplies, 2 roots and 21 accumulate steps, run in order by
// the microcode. One beat in flight at a time.
// Synchronous active-low reset restores default registers and zero state.
// A stalled output holds the finished result; in_ready returns once it moves.
// ----------------------------------------------------------------------------
module heston_path_step import hps_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_path_start,
  input  logic signed [15:0] in_normal_var,
  input  logic signed [15:0] in_normal_price,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_price,
  output logic [30:0]        out_variance,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int XW   = 32 + FRAC_BITS;
  localparam int XW2  = XW + (XW % 2);
  localparam int RTW  = XW2 / 2;
  localparam int RW   = RTW + 2;
  localparam int SCW  = $clog2(RTW);
  localparam logic [SCW-1:0] SQ_LAST = SCW'(RTW - 1);
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  state_t state_r;
  logic [PC_W-1:0] pc_r;
  uop_t u;

  logic [30:0] kappa_r, theta_r, sigma_r, dt_r, v0_r, s0_r;
  logic signed [31:0] rate_r;
  logic [30:0] v_r;
  logic signed [31:0] p_r;
  logic signed [15:0] zp_r, zv_r, zs_r;
  logic signed [31:0] t0_r, t1_r, t2_r, t3_r;
  logic signed [35:0] acc_r;
  logic flag_r;

  logic signed [31:0] ma_r;
  logic signed [33:0] mhi_r;
  logic [31:0] mlo_r;
  logic [4:0] mcnt_r;
  logic mul_wb_r;
  logic sqrt_wb_r;

  logic [XW2-1:0] xs_r;
  logic [RW-1:0] rem_r;
  logic [RTW-1:0] root_r;
  logic [SCW-1:0] scnt_r;

  logic signed [31:0] op_a, op_b;
  logic signed [33:0] maddend, msum;
  logic signed [63:0] prod, prod_sh;
  logic [32:0] mres, ares;
  logic [RW-1:0] rem2, trial;
  logic signed [31:0] wres;
  logic wovf;
  logic in_fire;

  assign u         = uop_at(pc_r);
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    case (u.a)
      SRC_KAPPA: op_a = {1'b0, kappa_r};
      SRC_THETA: op_a = {1'b0, theta_r};
      SRC_SIGMA: op_a = {1'b0, sigma_r};
      SRC_RATE:  op_a = rate_r;
      SRC_DT:    op_a = {1'b0, dt_r};
      SRC_V:     op_a = {1'b0, v_r};
      SRC_P:     op_a = p_r;
      SRC_ZV:    op_a = 32'(zv_r);
      SRC_ZS:    op_a = 32'(zs_r);
      SRC_ZP:    op_a = 32'(zp_r);
      SRC_T0:    op_a = t0_r;
      SRC_T1:    op_a = t1_r;
      SRC_T2:    op_a = t2_r;
      SRC_T3:    op_a = t3_r;
      SRC_ONE:   op_a = ONE_Q;
      SRC_ZSQ:   op_a = DRAW_ONE_SQ;
      default:   op_a = '0;
    endcase
    case (u.b)
      SRC_KAPPA: op_b = {1'b0, kappa_r};
      SRC_THETA: op_b = {1'b0, theta_r};
      SRC_SIGMA: op_b = {1'b0, sigma_r};
      SRC_RATE:  op_b = rate_r;
      SRC_DT:    op_b = {1'b0, dt_r};
      SRC_V:     op_b = {1'b0, v_r};
      SRC_P:     op_b = p_r;
      SRC_ZV:    op_b = 32'(zv_r);
      SRC_ZS:    op_b = 32'(zs_r);
      SRC_ZP:    op_b = 32'(zp_r);
      SRC_T0:    op_b = t0_r;
      SRC_T1:    op_b = t1_r;
      SRC_T2:    op_b = t2_r;
      SRC_T3:    op_b = t3_r;
      SRC_ONE:   op_b = ONE_Q;
      SRC_ZSQ:   op_b = DRAW_ONE_SQ;
      default:   op_b = '0;
    endcase
  end

  // shift-add multiplier, sign bit of the multiplier weighs negative
  always_comb begin
    if (mlo_r[0]) begin
      maddend = (mcnt_r == 5'd31) ? -34'(ma_r) : 34'(ma_r);
    end else begin
      maddend = '0;
    end
    msum = mhi_r + maddend;
    prod = {mhi_r[31:0], mlo_r};
    case (u.sh)
      SH_FRAC:  prod_sh = prod >>> FRAC_BITS;
      SH_DRAW:  prod_sh = prod >>> DRAW_BITS;
      SH_QUART: prod_sh = prod >>> QUART_BITS;
      default:  prod_sh = prod;
    endcase
    mres = sat32(prod_sh);
    ares = sat32(64'(acc_r));
  end

  always_comb begin
    rem2  = {rem_r[RW-3:0], xs_r[XW2-1 -: 2]};
    trial = {root_r, 2'b01};
  end

  always_comb begin
    if (mul_wb_r) begin
      wres = mres[31:0];
      wovf = mres[32];
    end else if (sqrt_wb_r) begin
      wres = 32'(root_r);
      wovf = 1'b0;
    end else begin
      wres = ares[31:0];
      wovf = ares[32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kappa_r <= 31'd1376256;
      theta_r <= 31'd6554;
      sigma_r <= 31'd19661;
      rate_r  <= 32'sd5898;
      dt_r    <= 31'd260;
      v0_r    <= 31'd2621;
      s0_r    <= 31'd6553600;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KAPPA: kappa_r <= cfg_data[30:0];
        REG_THETA: theta_r <= cfg_data[30:0];
        REG_SIGMA: sigma_r <= cfg_data[30:0];
        REG_RATE:  rate_r  <= cfg_data;
        REG_DT:    dt_r    <= cfg_data[30:0];
        REG_V0:    v0_r    <= cfg_data[30:0];
        REG_S0:    s0_r    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pc_r      <= '0;
      v_r       <= '0;
      p_r       <= '0;
      zp_r      <= '0;
      flag_r    <= 1'b0;
      out_valid <= 1'b0;
      mul_wb_r  <= 1'b0;
      sqrt_wb_r <= 1'b0;
      mcnt_r    <= '0;
      scnt_r    <= '0;
    end else begin
      if (out_valid && out_ready && state_r != S_PUSH) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            zv_r   <= in_normal_var;
            zs_r   <= in_normal_price;
            flag_r <= 1'b0;
            pc_r   <= '0;
            if (in_path_start) begin
              v_r     <= v0_r;
              p_r     <= {1'b0, s0_r};
              zp_r    <= in_normal_price;
              state_r <= S_PUSH;
            end else begin
              state_r <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          if (mul_wb_r || sqrt_wb_r || u.op == OP_SAT) begin
            case (u.dst)
              DST_T0: t0_r <= wres;
              DST_T1: t1_r <= wres;
              DST_T2: t2_r <= wres;
              DST_T3: t3_r <= wres;
              DST_V:  v_r  <= wres[31] ? '0 : wres[30:0];
              DST_P:  p_r  <= wres;
              default: ;
            endcase
            flag_r    <= flag_r | wovf;
            mul_wb_r  <= 1'b0;
            sqrt_wb_r <= 1'b0;
            if (pc_r == PROG_LAST) begin
              zp_r    <= zs_r;
              state_r <= S_PUSH;
            end else begin
              pc_r <= pc_r + 1'b1;
            end
          end else begin
            case (u.op)
              OP_LD:  begin acc_r <= 36'(op_a); pc_r <= pc_r + 1'b1; end
              OP_ADD: begin acc_r <= acc_r + 36'(op_a); pc_r <= pc_r + 1'b1; end
              OP_SUB: begin acc_r <= acc_r - 36'(op_a); pc_r <= pc_r + 1'b1; end
              OP_MUL: begin
                ma_r    <= op_a;
                mhi_r   <= '0;
                mlo_r   <= op_b;
                mcnt_r  <= '0;
                state_r <= S_MUL;
              end
              OP_SQRT: begin
                xs_r    <= XW2'(op_a[31] ? 31'd0 : op_a[30:0]) << FRAC_BITS;
                rem_r   <= '0;
                root_r  <= '0;
                scnt_r  <= '0;
                state_r <= S_SQRT;
              end
              default: pc_r <= pc_r + 1'b1;
            endcase
          end
        end
        S_MUL: begin
          mhi_r  <= msum >>> 1;
          mlo_r  <= {msum[0], mlo_r[31:1]};
          mcnt_r <= mcnt_r + 1'b1;
          if (mcnt_r == 5'd31) begin
            mul_wb_r <= 1'b1;
            state_r  <= S_ISSUE;
          end
        end
        S_SQRT: begin
          xs_r   <= xs_r << 2;
          scnt_r <= scnt_r + 1'b1;
          if (rem2 >= trial) begin
            rem_r  <= rem2 - trial;
            root_r <= {root_r[RTW-2:0], 1'b1};
          end else begin
            rem_r  <= rem2;
            root_r <= {root_r[RTW-2:0], 1'b0};
          end
          if (scnt_r == SQ_LAST) begin
            sqrt_wb_r <= 1'b1;
            state_r   <= S_ISSUE;
          end
        end
        S_PUSH: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            out_price     <= p_r;
            out_variance  <= v_r;
            out_saturated <= flag_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_push_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_PUSH))
    else $error("result appeared outside push");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("took a beat while busy");
  a_pc: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PROG_LAST)
    else $error("microcode pc out of range");
  a_wb: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_wb_r && sqrt_wb_r))
    else $error("two pending write-backs");
`endif

endmodule

// ===== test/heston_path_step_tb.sv =====
// ----------------------------------------------------------------------------
// heston_path_step_tb
// Self-checking bench for the Heston path stepper. A scoreboard class keeps
// its own fixed-point model of the variance and price recurrences and queues
// one expected beat per accepted input beat. Output beats are compared field
// by field. Stimulus: a directed opening, then random paths over several
// register settings (extremes, random), with random gaps and
// stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module heston_path_step_tb import hps_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam int FRAC = 16;
  localparam longint CYCLE_LIMIT = 5000000;

  typedef struct {
    logic signed [31:0] price;
    logic [30:0]        variance;
    logic               saturated;
  } path_beat_t;

  class hps_scoreboard;
    longint kappa, theta, sigma, rate, dt, v0, s0;
    longint cur_var, cur_price, prev_zs;
    bit hit;
    path_beat_t pending[$];
    int errors;

    function new();
      kappa = 1376256; theta = 6554; sigma = 19661; rate = 5898;
      dt = 260; v0 = 2621; s0 = 6553600;
      cur_var = 0; cur_price = 0; prev_zs = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      longint u31;
      u31 = longint'(data[30:0]);
      case (idx)
        REG_KAPPA: kappa = u31;
        REG_THETA: theta = u31;
        REG_SIGMA: sigma = u31;
        REG_RATE:  rate  = longint'(signed'(data));
        REG_DT:    dt    = u31;
        REG_V0:    v0    = u31;
        REG_S0:    s0    = u31;
        default: ;
      endcase
    endfunction

    function longint clip(longint x);
      if (x > Q_MAX) begin
        hit = 1; return Q_MAX;
      end
      if (x < Q_MIN) begin
        hit = 1; return Q_MIN;
      end
      return x;
    endfunction

    function longint fmul(longint a, longint b);
      return clip((a * b) >>> FRAC);
    endfunction

    function longint dmul(longint a, longint z);
      return clip((a * z) >>> 12);
    endfunction

    function longint quarter(longint q, longint z);
      longint zz;
      zz = z * z - (64'sd1 << 24);
      return clip((q * zz) >>> 26);
    endfunction

    function longint froot(longint x);
      longint unsigned r, b, n;
      if (x <= 0) return 0;
      n = longint'(x) << FRAC;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b); r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    function void note_input(bit start, logic signed [15:0] zvi, logic signed [15:0] zsi);
      path_beat_t e;
      longint zv, zs, v, p, drift, diff, corr, v1, inner, t1, t2, pr;
      zv = zvi; zs = zsi; v = cur_var; p = cur_price;
      hit = 0;
      if (start) begin
        cur_var = v0; cur_price = s0; prev_zs = zs;
        e.price = s0[31:0]; e.variance = v0[30:0]; e.saturated = 0;
        pending.push_back(e);
        return;
      end
      drift = fmul(fmul(kappa, clip(theta - v)), dt);
      diff  = dmul(fmul(sigma, froot(fmul(v, dt))), zv);
      corr  = quarter(fmul(fmul(sigma, sigma), dt), zv);
      v1 = clip(v + drift + diff + corr);
      if (v1 < 0) v1 = 0;
      inner = clip((64'sd1 << FRAC) + fmul(rate, dt) + dmul(froot(fmul(v1, dt)), zs));
      t1 = fmul(p, inner);
      t2 = quarter(fmul(fmul(p, p), dt), prev_zs);
      pr = clip(t1 + t2);
      cur_var = v1; cur_price = pr; prev_zs = zs;
      e.price = pr[31:0]; e.variance = v1[30:0]; e.saturated = hit;
      pending.push_back(e);
    endfunction

    function void check_result(logic signed [31:0] pr, logic [30:0] vr, logic sat);
      path_beat_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected out beat: price %0d var %0d", pr, vr);
        return;
      end
      e = pending.pop_front();
      if (pr !== e.price || vr !== e.variance || sat !== e.saturated) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: price %0d/%0d var %0d/%0d sat %0b/%0b (exp/act)",
                   e.price, pr, e.variance, vr, e.saturated, sat);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic in_path_start = 0;
  logic signed [15:0] in_normal_var = 0;
  logic signed [15:0] in_normal_price = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] out_price;
  logic [30:0] out_variance;
  logic out_saturated;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  hps_scoreboard sb = new();
  bit no_gaps = 0;
  bit long_hold = 0;
  bit start_hold = 0;
  int stall_left = 0;
  longint cycles = 0;

  heston_path_step dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("heston_path_step_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_result(out_price, out_variance, out_saturated);
        stall_left = no_gaps ? 0 : $urandom_range(0, 12);
      end
      if (long_hold) begin
        out_ready <= 0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  initial begin
    wait (start_hold);
    long_hold = 1;
    repeat (3000) @(posedge clk);
    long_hold = 0;
  end

  task automatic send_beat(bit st, logic signed [15:0] zv, logic signed [15:0] zs);
    int gap;
    in_valid <= 1;
    in_path_start <= st;
    in_normal_var <= zv;
    in_normal_price <= zs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(st, zv, zs);
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic load_regs(logic [31:0] k, logic [31:0] th, logic [31:0] sg,
                           logic [31:0] r, logic [31:0] d, logic [31:0] v,
                           logic [31:0] s);
    write_reg(REG_KAPPA, k);
    write_reg(REG_THETA, th);
    write_reg(REG_SIGMA, sg);
    write_reg(REG_RATE, r);
    write_reg(REG_DT, d);
    write_reg(REG_V0, v);
    write_reg(REG_S0, s);
  endtask

  function automatic logic signed [15:0] draw();
    if ($urandom_range(0, 4) == 0) return 16'($urandom());
    return 16'($urandom_range(0, 16384) - 8192);
  endfunction

  task automatic random_paths(int n);
    int left;
    left = n;
    while (left > 0) begin
      int len;
      len = $urandom_range(1, 30);
      if ($urandom_range(0, 9) != 0) begin
        send_beat(1, draw(), draw());
        left--;
      end
      for (int i = 0; i < len && left > 0; i++) begin
        send_beat($urandom_range(0, 19) == 0, draw(), draw());
        left--;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // steps from reset state, then a default path with edge draws
    send_beat(0, 16'sh1000, 16'sh1000);
    send_beat(0, -16'sh8000, 16'sh7fff);
    send_beat(1, 16'sh7fff, -16'sh8000);
    send_beat(0, 16'sh0000, 16'sh0000);
    send_beat(0, 16'sh7fff, 16'sh7fff);
    send_beat(0, -16'sh8000, -16'sh8000);
    send_beat(0, -16'sh8000, 16'sh1000);
    send_beat(0, 16'sh1000, -16'sh1000);
    send_beat(1, 16'sh0000, 16'sh7fff);
    send_beat(0, -16'sh7000, 16'sh0001);
    drain();

    // clamp of negative variance: big vol, zero theta
    load_regs(32'h0000_0000, 32'h0000_0000, 32'h0004_0000, 32'h0000_0000,
              32'h0001_0000, 32'h0001_0000, 32'h0064_0000);
    send_beat(1, 16'sh0, 16'sh0);
    send_beat(0, -16'sh8000, 16'sh0);
    send_beat(0, -16'sh8000, 16'sh7fff);
    send_beat(0, 16'sh7fff, -16'sh8000);
    drain();

    // extremes high: saturation everywhere
    load_regs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
              32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(1, 16'sh7fff, 16'sh7fff);
    send_beat(0, 16'sh7fff, 16'sh7fff);
    send_beat(0, -16'sh8000, -16'sh8000);
    random_paths(60);
    drain();

    // extremes low
    load_regs(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    send_beat(1, 16'sh7fff, -16'sh8000);
    send_beat(0, 16'sh7fff, -16'sh8000);
    random_paths(40);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) begin
        load_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom());
      end else begin
        load_regs($urandom_range(0, 5 << 16) | (ph[0] << 31), $urandom_range(0, 1 << 16),
                  $urandom_range(0, 1 << 16), $urandom_range(0, 1 << 14) - (1 << 13),
                  $urandom_range(1, 1 << 12), $urandom_range(0, 1 << 16),
                  $urandom_range(1 << 16, 200 << 16));
      end
      no_gaps = (ph == 2 || ph == 5);
      if (ph == 2) start_hold = 1;
      random_paths(110);
      drain();
      no_gaps = 0;
    end

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("heston_path_step_tb: done, clean");
    end else begin
      $display("heston_path_step_tb: done, errors");
    end
    $finish;
  end

endmodule
